// ===== hdl/sli_pkg.sv =====
package sli_pkg;

    localparam int CAPACITY = 128;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // wide enough to compare a position with the count plus one
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic       cmd;
        logic [7:0] position;
        logic [7:0] elem_age;
        logic [7:0] elem_name;
    } t_in_word;

    typedef struct packed {
        t_status    status;
        logic [7:0] removed_age;
        logic [7:0] removed_name;
        logic [7:0] list_length;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic rd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_more;
        logic drained;
    } t_dp_stat;

endpackage

// ===== hdl/sli_ctrl.sv =====
module sli_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sli_pkg::t_dp_stat i_stat,
    output sli_pkg::t_dp_cmd  o_cmd
);
    import sli_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load   = i_in_valid && (r_state == S_IDLE);
        o_cmd.rd     = (r_state == S_SHIFT) && i_stat.rd_more;
        // the result register must be free or emptying this cycle
        o_cmd.finish = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (i_stat.drained) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (o_cmd.finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("result not presented after commit");
    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SHIFT) |-> !o_cmd.rd)
        else $error("memory read outside shift");
    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SHIFT) && !o_in_ready)
        else $error("accepted word did not start shift");
`endif

endmodule

// ===== hdl/sli_dpath.sv =====
module sli_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sli_pkg::t_in_word  i_in_data,
    input  sli_pkg::t_dp_cmd   i_cmd,
    output sli_pkg::t_dp_stat  o_stat,
    output sli_pkg::t_out_word o_out_data
);
    import sli_pkg::*;

    logic [15:0]   mem [CAPACITY];

    logic          r_cmd;
    logic [7:0]    r_pos;
    logic [15:0]   r_elem;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_wr_addr;
    logic [15:0]   r_rd_data;
    logic          r_rdv;
    logic          r_first;
    logic [15:0]   r_removed;
    t_out_word     r_out;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] pos_in_x;
    logic [XW-1:0] cnt_x;
    logic          pos_ok;
    logic          full;
    logic          ok;
    t_status       status;
    logic [CW-1:0] n_count;
    logic          wr_shift;
    logic          wr_elem;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    always_comb begin
        pos_x    = XW'(r_pos);
        pos_in_x = XW'(i_in_data.position);
        cnt_x    = XW'(r_count);
        full     = (cnt_x == XW'(CAPACITY));
        if (r_cmd == CMD_DELETE) begin
            pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
            ok     = pos_ok;
        end else begin
            pos_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
            ok     = pos_ok && !full;
        end
        if (!pos_ok) begin
            status = ST_RANGE;
        end else if (!ok) begin
            status = ST_FULL;
        end else begin
            status = ST_DONE;
        end
        if (!ok) begin
            n_count = r_count;
        end else if (r_cmd == CMD_DELETE) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count + CW'(1);
        end
    end

    // the first word read on a delete is the removed entry, not moved
    assign wr_shift = r_rdv && !((r_cmd == CMD_DELETE) && r_first);
    assign wr_elem  = i_cmd.finish && (r_cmd == CMD_INSERT) && ok;
    assign wr_en    = wr_shift || wr_elem;
    assign wr_addr  = wr_elem ? AW'(pos_x - XW'(1)) : r_wr_addr;
    assign wr_data  = wr_elem ? r_elem : r_rd_data;

    assign o_stat.rd_more = ok && (r_left != '0);
    assign o_stat.drained = !o_stat.rd_more && !r_rdv;
    assign o_out_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in_data.cmd;
            r_pos  <= i_in_data.position;
            r_elem <= {i_in_data.elem_name, i_in_data.elem_age};
            r_left <= CW'(cnt_x - pos_in_x + XW'(1));
            if (i_in_data.cmd == CMD_DELETE) begin
                r_addr <= AW'(pos_in_x - XW'(1));
            end else begin
                r_addr <= AW'(cnt_x - XW'(1));
            end
        end else if (i_cmd.rd) begin
            r_left <= r_left - CW'(1);
            if (r_cmd == CMD_DELETE) begin
                r_addr    <= r_addr + AW'(1);
                r_wr_addr <= r_addr - AW'(1);
            end else begin
                r_addr    <= r_addr - AW'(1);
                r_wr_addr <= r_addr + AW'(1);
            end
        end
        if (r_rdv && r_first) begin
            r_removed <= r_rd_data;
        end
        if (i_cmd.finish) begin
            r_out.status      <= status;
            r_out.list_length <= 8'(XW'(n_count));
            if (ok && (r_cmd == CMD_DELETE)) begin
                r_out.removed_age  <= r_removed[7:0];
                r_out.removed_name <= r_removed[15:8];
            end else begin
                r_out.removed_age  <= '0;
                r_out.removed_name <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rdv   <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_rdv <= i_cmd.rd;
            if (i_cmd.load) begin
                r_first <= 1'b1;
            end else if (r_rdv) begin
                r_first <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("element count above capacity");
    a_drained_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_rdv && !i_cmd.rd)
        else $error("commit with shift still in flight");
    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_shift |-> (XW'(r_wr_addr) <= cnt_x))
        else $error("shift write beyond list end");
`endif

endmodule

// ===== hdl/sequential_list_insert_delete.sv =====
// ordered list of up to CAPACITY elements (age byte, name byte), held in a
// single memory with a registered read port.
// input channel: i_in_valid / o_in_ready / i_in_data. cmd selects insert
// before a 1-based position or delete at a position.
// output channel: o_out_valid / i_out_ready / o_out_data, one word per
// input word: status, removed element (zero unless a delete succeeds) and
// the list length after the operation.
// timing: an accepted word reads the n = length - position + 1 entries from
// the position on (none when rejected; a delete moves all but the first),
// one memory read and one write per cycle. the result is registered once
// the shift has drained and the result register is free, and a new word is
// taken in the cycle after that. the shift loop over the memory port means
// a new word is not taken until the last one has been committed.
// the result register lets the next word be accepted while a result is
// still waiting; if the receiver keeps stalling, the following commit
// waits until the register empties.
// reset (synchronous, active low) empties the list; memory contents are
// not cleared and are never read before written.
module sequential_list_insert_delete (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sli_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sli_pkg::t_out_word o_out_data
);
    import sli_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    sli_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== test/tb.sv =====
module tb;
    import sli_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  in_data = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_word o_out_data;

    sequential_list_insert_delete dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    // words waiting to be sent; a set pause bit holds the word back until
    // every earlier result has come back
    t_in_word  pending_words[$];
    bit        pause_flags[$];
    t_out_word expected_results[$];
    int        mismatch_count = 0;

    // list length as seen while the stimulus is planned
    int        plan_len = 0;

    // predicted list contents
    logic [7:0] list_age[CAPACITY];
    logic [7:0] list_name[CAPACITY];
    int         list_len = 0;

    int         send_gap = 0;
    int         stall_left = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_word apply_to_list(input t_in_word w);
        t_out_word r;
        int        pos;
        int        k;
        r = '0;
        r.status = ST_DONE;
        pos = w.position;
        if (w.cmd == CMD_INSERT) begin
            if (pos < 1 || pos > list_len + 1) begin
                r.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (k = list_len; k > pos - 1; k--) begin
                    list_age[k] = list_age[k - 1];
                    list_name[k] = list_name[k - 1];
                end
                list_age[pos - 1] = w.elem_age;
                list_name[pos - 1] = w.elem_name;
                list_len++;
            end
        end else begin
            if (pos < 1 || pos > list_len) begin
                r.status = ST_RANGE;
            end else begin
                r.removed_age = list_age[pos - 1];
                r.removed_name = list_name[pos - 1];
                for (k = pos; k < list_len; k++) begin
                    list_age[k - 1] = list_age[k];
                    list_name[k - 1] = list_name[k];
                end
                list_len--;
            end
        end
        r.list_length = list_len[7:0];
        return r;
    endfunction

    // no idling once the stimulus is nearly used up
    function automatic bit quiet_tail();
        return pending_words.size() < 50;
    endfunction

    task automatic queue_word(input logic c, input int pos, input logic [7:0] age,
                              input logic [7:0] name, input bit pause);
        t_in_word w;
        w.cmd = c;
        w.position = pos[7:0];
        w.elem_age = age;
        w.elem_name = name;
        pending_words.push_back(w);
        pause_flags.push_back(pause);
        if (c == CMD_INSERT) begin
            if (pos >= 1 && pos <= plan_len + 1 && plan_len < CAPACITY) plan_len++;
        end else begin
            if (pos >= 1 && pos <= plan_len) plan_len--;
        end
    endtask

    task automatic queue_random(input int ins_pct, input int bad_pct, input bit pause);
        logic c;
        int   pos;
        c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        if ($urandom_range(0, 99) < bad_pct || (c == CMD_DELETE && plan_len == 0)) begin
            pos = $urandom_range(0, 255);
        end else if (c == CMD_INSERT) begin
            pos = $urandom_range(1, plan_len + 1);
        end else begin
            pos = $urandom_range(1, plan_len);
        end
        queue_word(c, pos, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pause);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        logic holding;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            holding = in_valid;
            if (in_valid && o_in_ready) begin
                expected_results.push_back(apply_to_list(in_data));
                holding = 1'b0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (!quiet_tail() && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             (!pause_flags[0] || expected_results.size() == 0)) begin
                    in_valid <= 1'b1;
                    in_data <= pending_words.pop_front();
                    void'(pause_flags.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, list_length", o_out_data.list_length, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.removed_age !== want.removed_age)
                        report_mismatch("removed_age", o_out_data.removed_age,
                                        want.removed_age);
                    if (o_out_data.removed_name !== want.removed_name)
                        report_mismatch("removed_name", o_out_data.removed_name,
                                        want.removed_name);
                    if (o_out_data.list_length !== want.list_length)
                        report_mismatch("list_length", o_out_data.list_length,
                                        want.list_length);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        // edge cases on an empty and a short list
        queue_word(CMD_DELETE, 1, 8'hff, 8'hff, 1'b0);
        queue_word(CMD_DELETE, 0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_INSERT, 0, 8'h12, 8'h34, 1'b0);
        queue_word(CMD_INSERT, 2, 8'h12, 8'h34, 1'b0);
        queue_word(CMD_INSERT, 1, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_INSERT, 1, 8'hff, 8'hff, 1'b0);
        queue_word(CMD_INSERT, 3, 8'h55, 8'haa, 1'b0);
        queue_word(CMD_INSERT, 2, 8'haa, 8'h55, 1'b0);
        queue_word(CMD_INSERT, 6, 8'h01, 8'h02, 1'b0);
        queue_word(CMD_INSERT, 255, 8'h03, 8'h04, 1'b0);
        queue_word(CMD_DELETE, 5, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_DELETE, 255, 8'hff, 8'hff, 1'b0);
        queue_word(CMD_DELETE, 0, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_DELETE, 4, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_DELETE, 1, 8'hff, 8'hff, 1'b0);
        queue_word(CMD_DELETE, 2, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_DELETE, 1, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_DELETE, 1, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_INSERT, 1, 8'h80, 8'h01, 1'b0);
        queue_word(CMD_INSERT, 2, 8'h7f, 8'hfe, 1'b0);

        for (n = 0; n < 80; n++) queue_random(65, 10, 1'b0);

        // grow to a full list, then push against the limit
        n = 0;
        while (plan_len < CAPACITY) begin
            queue_word(CMD_INSERT, $urandom_range(1, plan_len + 1),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n == 0);
            n++;
        end
        queue_word(CMD_INSERT, 1, 8'h11, 8'h22, 1'b0);
        queue_word(CMD_INSERT, CAPACITY + 1, 8'h33, 8'h44, 1'b0);
        queue_word(CMD_INSERT, $urandom_range(1, CAPACITY), 8'h55, 8'h66, 1'b0);
        queue_word(CMD_INSERT, CAPACITY + 2, 8'h77, 8'h88, 1'b0);
        queue_word(CMD_INSERT, 255, 8'h99, 8'haa, 1'b0);
        queue_word(CMD_DELETE, CAPACITY + 1, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_DELETE, CAPACITY, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_INSERT, CAPACITY, 8'hbb, 8'hcc, 1'b0);
        queue_word(CMD_DELETE, 1, 8'h00, 8'h00, 1'b0);
        queue_word(CMD_INSERT, 1, 8'hdd, 8'hee, 1'b0);
        queue_word(CMD_DELETE, CAPACITY / 2, 8'h00, 8'h00, 1'b0);

        // drain toward empty, then mixed traffic on a short list
        for (n = 0; n < 160; n++) queue_random(25, 8, n == 0);
        for (n = 0; n < 40; n++) queue_random(50, 15, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sli_pkg.sv
hdl/sli_ctrl.sv
hdl/sli_dpath.sv
hdl/sequential_list_insert_delete.sv
test/tb.sv
